@@ rtl/khc_pkg.sv @@
// Shared types, sizes and helper functions of the k-mer histogram counter.
// Used by the controller, the datapath, the top level and the port checker.
package khc_pkg;

  // Longest word that is counted, and the width of one stored counter.
  localparam int MAX_K   = 8;
  localparam int COUNT_W = 32;

  // Fixed field widths of the stream items and of the register.
  localparam int OP_W    = 2;
  localparam int BASE_W  = 3;
  localparam int RIDX_W  = 16;
  localparam int WL_W    = 4;
  localparam int OUT_W   = 32;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 32;

  // Table geometry: two bits per base, one counter per word.
  localparam int AW          = 2 * MAX_K;
  localparam int TABLE_DEPTH = 1 << AW;
  localparam int K_W         = $clog2(MAX_K + 1);
  localparam int CMP_W       = (COUNT_W > OUT_W) ? COUNT_W : OUT_W;

  // Operation codes carried in tuser.
  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_FEED  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Input base codes; anything above the last valid code counts as N.
  localparam logic [BASE_W-1:0] BASE_A = 3'd0;
  localparam logic [BASE_W-1:0] BASE_C = 3'd1;
  localparam logic [BASE_W-1:0] BASE_G = 3'd2;
  localparam logic [BASE_W-1:0] BASE_T = 3'd3;

  // Word digit codes: A0 G1 C2 T3.
  localparam logic [1:0] WORD_A = 2'd0;
  localparam logic [1:0] WORD_G = 2'd1;
  localparam logic [1:0] WORD_C = 2'd2;
  localparam logic [1:0] WORD_T = 2'd3;

  // Reset value of the word length register.
  localparam logic [WL_W-1:0] WL_RESET = 4'd3;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    ST_CLEAR     = 5'b00001,
    ST_IDLE      = 5'b00010,
    ST_FETCH_CNT = 5'b00100,
    ST_UPDATE    = 5'b01000,
    ST_FETCH_RD  = 5'b10000
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;        // accept the offered request
    logic clear_wr;    // write one zero of the clearing pass
    logic fetch;       // read one counter from the table
    logic fetch_read;  // fetch at the read index instead of the word index
    logic update_wr;   // write back the incremented counter
    logic out_load;    // move the fetched counter into the output register
  } khc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_start;  // offered request is a start
    logic is_count;  // offered request is a base that completes a word
    logic is_read;   // offered request is a read
    logic clr_done;  // clearing pass is at its last entry
    logic out_free;  // output register can take a new result
  } khc_status_t;

  // Maps an input base code to its word digit.
  function automatic logic [1:0] word_code(input logic [BASE_W-1:0] b);
    logic [1:0] c;
    case (b)
      BASE_C:  c = WORD_C;
      BASE_G:  c = WORD_G;
      BASE_T:  c = WORD_T;
      default: c = WORD_A;
    endcase
    return c;
  endfunction

  // Clamps a stored counter to the output width.
  function automatic logic [OUT_W-1:0] sat_out(input logic [COUNT_W-1:0] v);
    logic [CMP_W-1:0] ext;
    logic [OUT_W-1:0] r;
    ext = CMP_W'(v);
    if (ext > CMP_W'({OUT_W{1'b1}})) begin
      r = '1;
    end else begin
      r = ext[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/khc_ctrl.sv @@
// Controller state machine of the k-mer histogram counter.
// Depends on khc_pkg for the state encoding and the command/status structs.
module khc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  khc_pkg::khc_status_t status_i,
  output khc_pkg::khc_cmd_t    cmd_o
);

  khc_pkg::ctrl_state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      khc_pkg::ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.clr_done) begin
          state_d = khc_pkg::ST_IDLE;
        end
      end
      khc_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.take = 1'b1;
          if (status_i.is_start) begin
            state_d = khc_pkg::ST_CLEAR;
          end else if (status_i.is_count) begin
            state_d = khc_pkg::ST_FETCH_CNT;
          end else if (status_i.is_read) begin
            state_d = khc_pkg::ST_FETCH_RD;
          end
        end
      end
      khc_pkg::ST_FETCH_CNT: begin
        cmd_o.fetch = 1'b1;
        state_d     = khc_pkg::ST_UPDATE;
      end
      khc_pkg::ST_UPDATE: begin
        cmd_o.update_wr = 1'b1;
        state_d         = khc_pkg::ST_IDLE;
      end
      khc_pkg::ST_FETCH_RD: begin
        // The counter is fetched once, then held until the output frees up.
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = khc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = khc_pkg::ST_CLEAR;
      end
    endcase
    // The read fetch runs on the cycle the request is taken.
    if (state_q == khc_pkg::ST_IDLE && req_valid_i && status_i.is_read
        && !status_i.is_start) begin
      cmd_o.fetch      = 1'b1;
      cmd_o.fetch_read = 1'b1;
    end
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= khc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/khc_datapath.sv @@
// Datapath of the k-mer histogram counter: window, run length, count table,
// clearing counter, word length register and output register. Uses khc_pkg.
module khc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [khc_pkg::WL_W-1:0]      cfg_wdata_i,
  input  logic [khc_pkg::OP_W-1:0]      op_i,
  input  logic [khc_pkg::BASE_W-1:0]    base_i,
  input  logic [khc_pkg::RIDX_W-1:0]    read_index_i,
  input  khc_pkg::khc_cmd_t             cmd_i,
  output khc_pkg::khc_status_t          status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [khc_pkg::OUT_W-1:0]     word_count_o
);

  logic [khc_pkg::WL_W-1:0]    word_length_q;
  logic [khc_pkg::AW-1:0]      window_q;
  logic [khc_pkg::K_W-1:0]     run_q, run_next;
  logic [khc_pkg::AW-1:0]      clr_cnt_q;
  logic [khc_pkg::AW-1:0]      addr_q;
  logic [khc_pkg::COUNT_W-1:0] rd_q;
  logic [khc_pkg::OUT_W-1:0]   out_q;
  logic                        out_valid_q;
  logic [khc_pkg::K_W-1:0]     k_eff;
  logic [khc_pkg::AW-1:0]      word_idx;
  logic [khc_pkg::AW-1:0]      fetch_addr;
  logic                        base_is_n;
  logic                        mem_we;
  logic [khc_pkg::AW-1:0]      mem_waddr;
  logic [khc_pkg::COUNT_W-1:0] mem_wdata;
  logic [khc_pkg::COUNT_W-1:0] mem_q [khc_pkg::TABLE_DEPTH];

  // Effective word length: zero acts as one, large values clamp.
  always_comb begin
    if (word_length_q == '0) begin
      k_eff = khc_pkg::K_W'(1);
    end else if (word_length_q > khc_pkg::WL_W'(khc_pkg::MAX_K)) begin
      k_eff = khc_pkg::K_W'(khc_pkg::MAX_K);
    end else begin
      k_eff = khc_pkg::K_W'(word_length_q);
    end
  end

  // Word index: the newest k digits, oldest digit in the lowest position.
  always_comb begin
    logic [khc_pkg::K_W-1:0] age;
    logic [khc_pkg::AW-1:0]  shifted;
    word_idx = '0;
    for (int p = 0; p < khc_pkg::MAX_K; p++) begin
      age     = k_eff - khc_pkg::K_W'(1) - khc_pkg::K_W'(p);
      shifted = window_q >> {age, 1'b0};
      if (khc_pkg::K_W'(p) < k_eff) begin
        word_idx[2*p +: 2] = shifted[1:0];
      end
    end
  end

  // Request decode for the controller.
  assign base_is_n = (base_i > khc_pkg::BASE_T);
  assign run_next  = (run_q < khc_pkg::K_W'(khc_pkg::MAX_K)) ? run_q + khc_pkg::K_W'(1)
                                                            : run_q;

  always_comb begin
    status_o          = '0;
    status_o.is_start = (op_i == khc_pkg::OP_START);
    status_o.is_count = (op_i == khc_pkg::OP_FEED) && !base_is_n && (run_next >= k_eff);
    status_o.is_read  = (op_i == khc_pkg::OP_READ);
    status_o.clr_done = &clr_cnt_q;
    status_o.out_free = !out_valid_q || out_ready_i;
  end

  // Table port selection.
  assign fetch_addr = cmd_i.fetch_read ? khc_pkg::AW'(read_index_i) : word_idx;
  assign mem_we     = cmd_i.clear_wr || cmd_i.update_wr;
  assign mem_waddr  = cmd_i.clear_wr ? clr_cnt_q : addr_q;
  assign mem_wdata  = cmd_i.clear_wr ? '0 :
                      ((&rd_q) ? rd_q : rd_q + khc_pkg::COUNT_W'(1));

  // Count table with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.fetch) begin
      rd_q   <= mem_q[fetch_addr];
      addr_q <= fetch_addr;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= khc_pkg::sat_out(rd_q);
    end
  end

  // Control state: register, window, run length, clearing counter, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_length_q <= khc_pkg::WL_RESET;
      window_q      <= '0;
      run_q         <= '0;
      clr_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        word_length_q <= cfg_wdata_i;
      end
      if (cmd_i.take && op_i == khc_pkg::OP_START) begin
        window_q  <= '0;
        run_q     <= '0;
        clr_cnt_q <= '0;
      end else if (cmd_i.take && op_i == khc_pkg::OP_FEED) begin
        if (base_is_n) begin
          window_q <= '0;
          run_q    <= '0;
        end else begin
          window_q <= khc_pkg::AW'({window_q, khc_pkg::word_code(base_i)});
          run_q    <= run_next;
        end
      end else if (cmd_i.clear_wr) begin
        clr_cnt_q <= clr_cnt_q + khc_pkg::AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign word_count_o = out_q;

endmodule

@@ rtl/kmer_histogram_counter_core.sv @@
// Top level of the k-mer histogram counter: stream ports and register port.
// Instantiates khc_ctrl and khc_datapath; uses khc_pkg for sizes and types.
//
//  Channel         Direction  Moves
//  s_axis          in         request: tuser = op, tdata = base, read_index
//  m_axis          out        result:  tdata = word_count
//  cfg_we_i/wdata  in         word length register write
//
// A base that completes no word is only taken; one that completes a word then passes
// through a table fetch and a write-back (states FETCH_CNT, UPDATE). A read is taken
// with its table fetch, then waits in FETCH_RD for the output register. A start is
// followed by a clearing pass over all 65536 table entries, one entry per cycle.
// After reset the same clearing pass runs before the first request
// is taken. A stalled result sits in the output register while the next
// request is still accepted.
module kmer_histogram_counter_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [khc_pkg::WL_W-1:0]        cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: base [2:0], read_index [18:3], zero fill [23:19]
  input  logic [khc_pkg::S_DATA_W-1:0]    s_axis_tdata,
  // tuser: op [1:0]
  input  logic [khc_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: word_count [31:0]
  output logic [khc_pkg::M_DATA_W-1:0]    m_axis_tdata
);

  khc_pkg::khc_cmd_t    cmd;
  khc_pkg::khc_status_t status;
  logic [khc_pkg::OUT_W-1:0] word_count;

  khc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  khc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .op_i         (s_axis_tuser),
    .base_i       (s_axis_tdata[khc_pkg::BASE_W-1:0]),
    .read_index_i (s_axis_tdata[khc_pkg::BASE_W +: khc_pkg::RIDX_W]),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .word_count_o (word_count)
  );

  assign m_axis_tdata = khc_pkg::M_DATA_W'(word_count);

endmodule

@@ rtl/khc_checker.sv @@
// Port-level checks of the k-mer histogram counter, bound to the top level.
// Uses khc_pkg for the operation codes and port widths.
module khc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [khc_pkg::OP_W-1:0]     s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [khc_pkg::M_DATA_W-1:0] m_axis_tdata
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or vanished while stalled");

  // A start request launches the clearing pass, so no request follows at once.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser == khc_pkg::OP_START |=> !s_axis_tready)
    else $error("request taken during clearing pass");

  // A read request keeps the input side busy until its counter is loaded for output.
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser == khc_pkg::OP_READ |=> !s_axis_tready)
    else $error("request taken while a read is pending");

  // A base never produces a result on its own.
  a_feed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser == khc_pkg::OP_FEED && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result produced by a base request");

  // Coming out of reset the table is being cleared.
  a_reset_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("request taken before the clearing pass after reset");

endmodule

bind kmer_histogram_counter_core khc_checker u_khc_checker (.*);

@@ sim/kmer_histogram_counter_core_test.sv @@
// Self-checking testbench for the k-mer histogram counter core.
// Drives requests and checks every returned word count against a local predictor.
// Depends on khc_pkg and kmer_histogram_counter_core.
`timescale 1ns / 1ps

module kmer_histogram_counter_core_test;

  // Codes that the package does not name.
  localparam logic [khc_pkg::OP_W-1:0]   OP_NONE = 2'd3;
  localparam logic [khc_pkg::BASE_W-1:0] BASE_N  = 3'd4;

  // Cycles without any handshake before the run is declared hung. One clearing
  // pass is much shorter, so this allows several of them back to back.
  localparam int STALL_LIMIT = 300000;
  localparam int RAND_PHASES = 9;
  localparam int PHASE_REQS  = 45;

  // One row of the directed stimulus; fixed rows carry a hand-written count.
  typedef struct {
    logic [khc_pkg::OP_W-1:0]   op;
    logic [khc_pkg::BASE_W-1:0] base;
    logic [khc_pkg::RIDX_W-1:0] ridx;
    bit                         fixed;
    logic [khc_pkg::OUT_W-1:0]  want;
  } plan_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [khc_pkg::WL_W-1:0]      cfg_wdata_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [khc_pkg::S_DATA_W-1:0]  s_axis_tdata;
  logic [khc_pkg::OP_W-1:0]      s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [khc_pkg::M_DATA_W-1:0]  m_axis_tdata;

  // Predictor state: word length, base window, valid run and sparse count table.
  logic [khc_pkg::WL_W-1:0]      word_len;
  logic [khc_pkg::AW-1:0]        window;
  int                            valid_run;
  logic [khc_pkg::COUNT_W-1:0]   tally [int unsigned];
  int unsigned                   recent_words [$];
  logic [1:0]                    digit_of [4];

  // Counts still owed by the block, oldest first.
  logic [khc_pkg::OUT_W-1:0]     pending_counts [$];
  logic [khc_pkg::OUT_W-1:0]     want_count;

  int send_idle_pct;
  int recv_idle_pct;
  int errors;
  int reqs_sent;
  int counts_checked;
  int clears_sent;
  int starts_left;
  int idle_cycles;

  int wl_plan [RAND_PHASES] = '{0, 15, 1, 8, 6, 2, 12, 5, 7};

  plan_row_t directed [] = '{
    '{khc_pkg::OP_READ, khc_pkg::BASE_A, 16'h0000, 1'b1, 32'd0},
    '{khc_pkg::OP_READ, khc_pkg::BASE_A, 16'hFFFF, 1'b1, 32'd0},
    '{khc_pkg::OP_FEED, khc_pkg::BASE_A, 16'h0000, 1'b0, 32'd0},
    '{khc_pkg::OP_FEED, khc_pkg::BASE_C, 16'h0000, 1'b0, 32'd0},
    '{khc_pkg::OP_FEED, khc_pkg::BASE_G, 16'h0000, 1'b0, 32'd0},
    '{khc_pkg::OP_FEED, khc_pkg::BASE_T, 16'h0000, 1'b0, 32'd0},
    '{khc_pkg::OP_READ, khc_pkg::BASE_A, 16'd24,   1'b0, 32'd0},
    '{khc_pkg::OP_FEED, BASE_N,          16'h0000, 1'b0, 32'd0},
    '{khc_pkg::OP_FEED, khc_pkg::BASE_T, 16'h0000, 1'b0, 32'd0},
    '{khc_pkg::OP_FEED, 3'd7,            16'h0000, 1'b0, 32'd0},
    '{khc_pkg::OP_FEED, khc_pkg::BASE_A, 16'h0000, 1'b0, 32'd0},
    '{khc_pkg::OP_FEED, khc_pkg::BASE_A, 16'h0000, 1'b0, 32'd0},
    '{khc_pkg::OP_FEED, khc_pkg::BASE_A, 16'h0000, 1'b0, 32'd0},
    '{khc_pkg::OP_FEED, 3'd5,            16'h0000, 1'b0, 32'd0},
    '{OP_NONE,          3'd6,            16'hFFFF, 1'b0, 32'd0},
    '{khc_pkg::OP_READ, khc_pkg::BASE_A, 16'h0000, 1'b0, 32'd0},
    '{khc_pkg::OP_FEED, khc_pkg::BASE_T, 16'h0000, 1'b0, 32'd0},
    '{khc_pkg::OP_FEED, khc_pkg::BASE_T, 16'h0000, 1'b0, 32'd0},
    '{khc_pkg::OP_FEED, khc_pkg::BASE_T, 16'h0000, 1'b0, 32'd0},
    '{khc_pkg::OP_READ, khc_pkg::BASE_A, 16'd63,   1'b0, 32'd0},
    '{khc_pkg::OP_READ, khc_pkg::BASE_A, 16'hAAAA, 1'b0, 32'd0},
    '{khc_pkg::OP_START, 3'd7,           16'h5555, 1'b0, 32'd0},
    '{khc_pkg::OP_READ, khc_pkg::BASE_A, 16'd24,   1'b1, 32'd0},
    '{khc_pkg::OP_READ, khc_pkg::BASE_A, 16'd63,   1'b1, 32'd0}
  };

  kmer_histogram_counter_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Free-running clock.
  always #5 clk_i = ~clk_i;

  // Result side backpressure, changed at the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare each returned count with the oldest outstanding read.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      counts_checked++;
      if (pending_counts.size() == 0) begin
        $error("word_count returned with no read outstanding: actual %0d", m_axis_tdata);
        errors++;
      end else begin
        want_count = pending_counts.pop_front();
        if (m_axis_tdata !== want_count) begin
          $error("word_count mismatch: expected %0d, actual %0d", want_count, m_axis_tdata);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves anything.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without a handshake", idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Applies one accepted request to the predictor and returns the count a read owes.
  task automatic predict(input logic [khc_pkg::OP_W-1:0] op,
                         input logic [khc_pkg::BASE_W-1:0] base,
                         input logic [khc_pkg::RIDX_W-1:0] ridx, output bit has_count,
                         output logic [khc_pkg::OUT_W-1:0] count);
    int k;
    int unsigned idx;
    has_count = 1'b0;
    count = '0;
    case (op)
      khc_pkg::OP_START: begin
        tally.delete();
        window = '0;
        valid_run = 0;
      end
      khc_pkg::OP_FEED: begin
        // A zero length counts single bases; anything past MAX_K is clamped.
        k = (word_len == 0) ? 1 :
            ((word_len > khc_pkg::MAX_K) ? khc_pkg::MAX_K : int'(word_len));
        if (base > khc_pkg::BASE_T) begin
          window = '0;
          valid_run = 0;
        end else begin
          window = {window[khc_pkg::AW-3:0], digit_of[base[1:0]]};
          if (valid_run < khc_pkg::MAX_K) valid_run++;
          if (valid_run >= k) begin
            // The newest base is the last digit of the word, so it has the top weight.
            idx = 0;
            for (int a = 0; a < k; a++) begin
              idx |= int'(window[2*a +: 2]) << (2 * (k - 1 - a));
            end
            if (!tally.exists(idx)) tally[idx] = '0;
            if (tally[idx] != '1) tally[idx] = tally[idx] + 1'b1;
            recent_words.push_back(idx);
            if (recent_words.size() > 16) void'(recent_words.pop_front());
          end
        end
      end
      khc_pkg::OP_READ: begin
        has_count = 1'b1;
        count = tally.exists(ridx) ? tally[ridx] : '0;
      end
      default: begin
      end
    endcase
  endtask

  // Offers one request after a random gap and waits for it to be taken.
  // Called and returns at a falling edge; valid stays high for a following request.
  task automatic send_req(input logic [khc_pkg::OP_W-1:0] op,
                          input logic [khc_pkg::BASE_W-1:0] base,
                          input logic [khc_pkg::RIDX_W-1:0] ridx, input bit fixed = 1'b0,
                          input logic [khc_pkg::OUT_W-1:0] want = '0);
    bit has_count;
    logic [khc_pkg::OUT_W-1:0] count;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(khc_pkg::S_DATA_W-khc_pkg::RIDX_W-khc_pkg::BASE_W){1'b0}},
                      ridx, base};
    do @(posedge clk_i); while (!s_axis_tready);
    predict(op, base, ridx, has_count, count);
    if (has_count) pending_counts.push_back(fixed ? want : count);
    if (op != OP_NONE) reqs_sent++;
    if (op == khc_pkg::OP_START) clears_sent++;
    @(negedge clk_i);
  endtask

  // Holds requests back until every outstanding count has come back.
  task automatic wait_for_counts();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_counts.size() != 0);
  endtask

  // Writes the word length register while the block is quiet.
  task automatic write_word_length(input logic [khc_pkg::WL_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    word_len = value;
  endtask

  // One random phase: mostly base runs with a recurring motif, plus reads of
  // words just counted, some N bases, ignored ops and the odd table clear.
  task automatic run_phase(input logic [khc_pkg::WL_W-1:0] wl, input int n_reqs);
    int done;
    int r;
    int pos;
    logic [khc_pkg::BASE_W-1:0] motif [3];
    logic [khc_pkg::BASE_W-1:0] b;
    logic [khc_pkg::RIDX_W-1:0] ri;
    write_word_length(wl);
    foreach (motif[i]) motif[i] = khc_pkg::BASE_W'($urandom_range(0, 3));
    done = 0;
    pos = 0;
    while (done < n_reqs) begin
      if ($urandom_range(0, 39) == 0) wait_for_counts();
      r = $urandom_range(0, 199);
      b = khc_pkg::BASE_W'($urandom_range(0, 7));
      ri = khc_pkg::RIDX_W'($urandom_range(0, 65535));
      if (r < 2 && starts_left > 0) begin
        starts_left--;
        send_req(khc_pkg::OP_START, b, ri);
        done++;
      end else if (r < 120) begin
        if ($urandom_range(0, 1) == 1) begin
          b = motif[pos % 3];
          pos++;
        end else begin
          b = khc_pkg::BASE_W'($urandom_range(0, 3));
        end
        send_req(khc_pkg::OP_FEED, b, ri);
        done++;
      end else if (r < 132) begin
        send_req(khc_pkg::OP_FEED, khc_pkg::BASE_W'($urandom_range(4, 7)), ri);
        done++;
      end else if (r < 138) begin
        send_req(OP_NONE, b, ri);
      end else begin
        if (recent_words.size() != 0 && $urandom_range(0, 9) < 7) begin
          ri = khc_pkg::RIDX_W'(recent_words[$urandom_range(0, recent_words.size() - 1)]);
        end
        send_req(khc_pkg::OP_READ, b, ri);
        done++;
      end
    end
    // Closing with a read makes sure any clear or write-back has finished.
    send_req(khc_pkg::OP_READ, khc_pkg::BASE_A, khc_pkg::RIDX_W'(0));
    wait_for_counts();
    repeat (16) @(negedge clk_i);
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = khc_pkg::OP_START;
    m_axis_tready = 1'b0;
    digit_of[2'(khc_pkg::BASE_A)] = khc_pkg::WORD_A;
    digit_of[2'(khc_pkg::BASE_C)] = khc_pkg::WORD_C;
    digit_of[2'(khc_pkg::BASE_G)] = khc_pkg::WORD_G;
    digit_of[2'(khc_pkg::BASE_T)] = khc_pkg::WORD_T;
    word_len       = khc_pkg::WL_RESET;
    window         = '0;
    valid_run      = 0;
    errors         = 0;
    reqs_sent      = 0;
    counts_checked = 0;
    clears_sent    = 0;
    starts_left    = 3;
    idle_cycles    = 0;
    send_idle_pct  = 34;
    recv_idle_pct  = 82;

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows at the reset word length.
    foreach (directed[i]) begin
      send_req(directed[i].op, directed[i].base, directed[i].ridx,
               directed[i].fixed, directed[i].want);
    end
    wait_for_counts();
    repeat (16) @(negedge clk_i);

    // Random phases under three idle mixes, three word lengths each.
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p / 3)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      run_phase(khc_pkg::WL_W'(wl_plan[p]), PHASE_REQS);
    end

    wait_for_counts();
    repeat (16) @(negedge clk_i);

    $display("Sent %0d requests including %0d table clears; checked %0d word counts.",
             reqs_sent, clears_sent, counts_checked);
    $display("Word lengths 3, 0, 15, 1, 8, 6, 2, 12, 5 and 7 under three stall mixes.");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/khc_pkg.sv
rtl/khc_ctrl.sv
rtl/khc_datapath.sv
rtl/kmer_histogram_counter_core.sv
rtl/khc_checker.sv
sim/kmer_histogram_counter_core_test.sv
